// ----- hdl/ocsv_pkg.sv -----
package ocsv_pkg;

   localparam int CODE_CHARS        = 8;
   localparam int PRICE_FRAC_DIGITS = 4;
   localparam int TIME_DIGITS       = 12;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BAD   = 2'd1;
   localparam logic [1:0] STATUS_OVF   = 2'd2;
   localparam logic [1:0] STATUS_EARLY = 2'd3;

   localparam logic [3:0] FLD_ID     = 4'd0;
   localparam logic [3:0] FLD_CODE   = 4'd1;
   localparam logic [3:0] FLD_SIDE   = 4'd2;
   localparam logic [3:0] FLD_TIME   = 4'd3;
   localparam logic [3:0] FLD_ORDER  = 4'd4;
   localparam logic [3:0] FLD_ACTION = 4'd5;
   localparam logic [3:0] FLD_PRICE  = 4'd6;
   localparam logic [3:0] FLD_QTY    = 4'd7;
   localparam logic [3:0] FLD_TREF   = 4'd8;
   localparam logic [3:0] FLD_TPRICE = 4'd9;

   localparam logic [1:0] ACTION_TRADE = 2'd2;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_S     = 8'h53;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       line_end;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] event_id;
      logic [63:0]        security_code;
      logic               is_sell;
      logic [38:0]        time_us;
      logic [63:0]        order_ref;
      logic [1:0]         action_code;
      logic [47:0]        price;
      logic signed [31:0] quantity;
      logic [63:0]        trade_ref;
      logic [47:0]        trade_price;
   } rsp_word_type;

   function automatic logic [26:0] pow10(input logic [3:0] n);
      logic [26:0] v;
      unique case (n)
         4'd0:    v = 27'd1;
         4'd1:    v = 27'd10;
         4'd2:    v = 27'd100;
         4'd3:    v = 27'd1000;
         4'd4:    v = 27'd10000;
         4'd5:    v = 27'd100000;
         4'd6:    v = 27'd1000000;
         4'd7:    v = 27'd10000000;
         4'd8:    v = 27'd100000000;
         default: v = 27'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/ocsv_time_conv.sv -----
module ocsv_time_conv (
   input  logic        clock,
   input  logic [47:0] time_bcd,
   output logic [38:0] time_us
);
   import ocsv_pkg::*;

   logic [38:0] time_us_ff;
   logic [38:0] time_us_in;
   logic [6:0]  hh, mm, ss;
   logic [9:0]  ms, us;

   always_comb begin
      hh = 7'(time_bcd[47:44] * 4'd10) + 7'(time_bcd[43:40]);
      mm = 7'(time_bcd[39:36] * 4'd10) + 7'(time_bcd[35:32]);
      ss = 7'(time_bcd[31:28] * 4'd10) + 7'(time_bcd[27:24]);
      ms = 10'(time_bcd[23:20] * 7'd100) + 10'(time_bcd[19:16] * 4'd10) + 10'(time_bcd[15:12]);
      us = 10'(time_bcd[11:8] * 7'd100) + 10'(time_bcd[7:4] * 4'd10) + 10'(time_bcd[3:0]);
      time_us_in = 39'(hh * 39'd3600000000) + 39'(mm * 39'd60000000)
                 + 39'(ss * 39'd1000000) + 39'(ms * 39'd1000) + 39'(us);
   end

   always_ff @(posedge clock) begin
      time_us_ff <= time_us_in;
   end

   assign time_us = time_us_ff;

endmodule

// ----- hdl/ocsv_parser.sv -----
module ocsv_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ocsv_pkg::req_word_type req_word,
   input  logic [38:0]           time_us,
   output logic [47:0]           time_bcd,
   output logic                  rsp_write,
   output ocsv_pkg::rsp_word_type rsp_data
);
   import ocsv_pkg::*;

   logic [3:0]  field_ff, field_in;
   logic [63:0] acc_ff, acc_in;
   logic [4:0]  dc_ff, dc_in;
   logic        neg_ff, neg_in;
   logic [3:0]  fs_ff, fs_in;
   logic [47:0] bcd_ff, bcd_in;
   logic [1:0]  err_ff, err_in;
   logic [31:0] id_ff, id_in;
   logic [63:0] code_ff, code_in;
   logic        sell_ff, sell_in;
   logic [47:0] tbcd_ff, tbcd_in;
   logic [63:0] oref_ff, oref_in;
   logic [1:0]  act_ff, act_in;
   logic [47:0] price_ff, price_in;
   logic [31:0] qty_ff, qty_in;
   logic [63:0] tref_ff, tref_in;

   logic [7:0]  c;
   logic        is_digit, is_comma, is_alnum, trade, start;
   logic [3:0]  d;
   logic [1:0]  err_new, err_fin;
   logic [35:0] dec_nv;
   logic [35:0] dec_lim;
   logic [67:0] wide_nv;
   logic [55:0] int_nv, frac_nv;
   logic [4:0]  dc_bump;
   logic [31:0] acc_neg;

   always_comb begin
      c        = req_word.char_byte;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_comma = (c == CHAR_COMMA);
      is_alnum = is_digit || ((c >= CHAR_A) && (c <= CHAR_Z));
      d        = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
      trade    = (act_ff == ACTION_TRADE);
      dec_nv   = {1'b0, acc_ff[31:0], 3'b0} + {3'b0, acc_ff[31:0], 1'b0} + 36'(d);
      dec_lim  = neg_ff ? 36'h080000000 : 36'h07FFFFFFF;
      wide_nv  = {1'b0, acc_ff, 3'b0} + {3'b0, acc_ff, 1'b0} + 68'(d);
      int_nv   = {5'b0, acc_ff[47:0], 3'b0} + {7'b0, acc_ff[47:0], 1'b0}
               + 56'(d * pow10(4'(PRICE_FRAC_DIGITS)));
      frac_nv  = {8'b0, acc_ff[47:0]} + 56'(d * pow10(4'(PRICE_FRAC_DIGITS) - fs_ff));
      dc_bump  = (dc_ff == 5'd31) ? dc_ff : dc_ff + 5'd1;
      acc_neg  = neg_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
   end

   always_comb begin
      field_in = field_ff;
      acc_in   = acc_ff;
      dc_in    = dc_ff;
      neg_in   = neg_ff;
      fs_in    = fs_ff;
      bcd_in   = bcd_ff;
      id_in    = id_ff;
      code_in  = code_ff;
      sell_in  = sell_ff;
      tbcd_in  = tbcd_ff;
      oref_in  = oref_ff;
      act_in   = act_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      tref_in  = tref_ff;
      err_new  = STATUS_OK;
      start    = 1'b0;
      if (accept && (err_ff == STATUS_OK)) begin
         if ((field_ff >= FLD_TREF) && !trade) begin
            if ((field_ff == FLD_TREF) && is_comma) begin
               field_in = FLD_TPRICE;
               start    = 1'b1;
            end else begin
               err_new = STATUS_BAD;
            end
         end else if (is_comma) begin
            if (field_ff >= FLD_TPRICE) begin
               err_new = STATUS_BAD;
            end else begin
               unique case (field_ff)
                  FLD_CODE: code_in = acc_ff;
                  FLD_SIDE: begin
                     if (dc_ff != 5'd1) err_new = STATUS_BAD;
                     else sell_in = acc_ff[0];
                  end
                  FLD_ACTION: begin
                     if (dc_ff != 5'd1) err_new = STATUS_BAD;
                     else act_in = acc_ff[1:0];
                  end
                  FLD_TIME: begin
                     if (dc_ff == 5'd0) err_new = STATUS_BAD;
                     else tbcd_in = bcd_ff;
                  end
                  FLD_ID: begin
                     if (dc_ff == 5'd0) err_new = STATUS_BAD;
                     else id_in = acc_neg;
                  end
                  FLD_QTY: begin
                     if (dc_ff == 5'd0) err_new = STATUS_BAD;
                     else qty_in = acc_neg;
                  end
                  FLD_ORDER: begin
                     if (dc_ff == 5'd0) err_new = STATUS_BAD;
                     else oref_in = acc_ff;
                  end
                  FLD_PRICE: begin
                     if (dc_ff == 5'd0) err_new = STATUS_BAD;
                     else price_in = acc_ff[47:0];
                  end
                  default: begin
                     if (dc_ff == 5'd0) err_new = STATUS_BAD;
                     else tref_in = acc_ff;
                  end
               endcase
               if (err_new == STATUS_OK) begin
                  field_in = field_ff + 4'd1;
                  start    = 1'b1;
               end
            end
         end else begin
            unique case (field_ff)
               FLD_ID, FLD_QTY: begin
                  if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
                     if ((dc_ff == 5'd0) && (fs_ff == 4'd0)) begin
                        fs_in  = 4'd1;
                        neg_in = (c == CHAR_MINUS);
                     end else begin
                        err_new = STATUS_BAD;
                     end
                  end else if (is_digit) begin
                     if (dec_nv > dec_lim) err_new = STATUS_OVF;
                     else begin
                        acc_in = 64'(dec_nv);
                        dc_in  = dc_bump;
                     end
                  end else begin
                     err_new = STATUS_BAD;
                  end
               end
               FLD_CODE: begin
                  if (!is_alnum) err_new = STATUS_BAD;
                  else if (dc_ff >= 5'(CODE_CHARS)) err_new = STATUS_OVF;
                  else begin
                     for (int k = 0; k < 8; k++) begin
                        if (dc_ff[2:0] == 3'(k)) acc_in[63 - 8 * k -: 8] = c;
                     end
                     dc_in = dc_ff + 5'd1;
                  end
               end
               FLD_SIDE: begin
                  if ((dc_ff == 5'd0) && ((c == CHAR_B) || (c == CHAR_S))) begin
                     acc_in = {63'b0, (c == CHAR_S)};
                     dc_in  = 5'd1;
                  end else begin
                     err_new = STATUS_BAD;
                  end
               end
               FLD_ACTION: begin
                  if ((dc_ff == 5'd0) && (c >= CHAR_ZERO) && (c <= CHAR_TWO)) begin
                     acc_in = 64'(d);
                     dc_in  = 5'd1;
                  end else begin
                     err_new = STATUS_BAD;
                  end
               end
               FLD_TIME: begin
                  if (!is_digit) err_new = STATUS_BAD;
                  else if (bcd_ff[4 * TIME_DIGITS - 1 -: 4] != 4'd0) err_new = STATUS_OVF;
                  else begin
                     bcd_in = {bcd_ff[43:0], d};
                     dc_in  = dc_bump;
                  end
               end
               FLD_ORDER, FLD_TREF: begin
                  if (!is_digit) err_new = STATUS_BAD;
                  else if (wide_nv[67:64] != 4'd0) err_new = STATUS_OVF;
                  else begin
                     acc_in = wide_nv[63:0];
                     dc_in  = dc_bump;
                  end
               end
               FLD_PRICE, FLD_TPRICE: begin
                  if (c == CHAR_POINT) begin
                     if (fs_ff == 4'd0) fs_in = 4'd1;
                     else err_new = STATUS_BAD;
                  end else if (is_digit) begin
                     if (fs_ff == 4'd0) begin
                        if (int_nv[55:48] != 8'd0) err_new = STATUS_OVF;
                        else acc_in = {16'b0, int_nv[47:0]};
                     end else if (fs_ff <= 4'(PRICE_FRAC_DIGITS)) begin
                        if (frac_nv[55:48] != 8'd0) err_new = STATUS_OVF;
                        else begin
                           acc_in = {16'b0, frac_nv[47:0]};
                           fs_in  = fs_ff + 4'd1;
                        end
                     end
                     if (err_new == STATUS_OK) dc_in = dc_bump;
                  end else begin
                     err_new = STATUS_BAD;
                  end
               end
               default: err_new = STATUS_BAD;
            endcase
         end
      end
      if (start) begin
         acc_in = '0;
         bcd_in = '0;
         dc_in  = '0;
         neg_in = 1'b0;
         fs_in  = '0;
      end
      if (accept && req_word.line_end && (err_ff == STATUS_OK) && (err_new == STATUS_OK)) begin
         if (field_in != FLD_TPRICE) err_new = STATUS_EARLY;
         else if (trade && (dc_in == 5'd0)) err_new = STATUS_BAD;
      end
      err_fin = (err_ff != STATUS_OK) ? err_ff : err_new;
      err_in  = err_fin;
   end

   assign rsp_write = accept && req_word.line_end;
   assign time_bcd  = tbcd_ff;

   always_comb begin
      rsp_data        = '0;
      rsp_data.status = err_fin;
      if (err_fin == STATUS_OK) begin
         rsp_data.event_id      = id_ff;
         rsp_data.security_code = code_ff;
         rsp_data.is_sell       = sell_ff;
         rsp_data.time_us       = time_us;
         rsp_data.order_ref     = oref_ff;
         rsp_data.action_code   = act_ff;
         rsp_data.price         = price_ff;
         rsp_data.quantity      = qty_ff;
         rsp_data.trade_ref     = tref_ff;
         rsp_data.trade_price   = trade ? acc_in[47:0] : 48'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || rsp_write) begin
         field_ff <= FLD_ID;
         acc_ff   <= '0;
         dc_ff    <= '0;
         neg_ff   <= 1'b0;
         fs_ff    <= '0;
         bcd_ff   <= '0;
         err_ff   <= STATUS_OK;
         id_ff    <= '0;
         code_ff  <= '0;
         sell_ff  <= 1'b0;
         tbcd_ff  <= '0;
         oref_ff  <= '0;
         act_ff   <= '0;
         price_ff <= '0;
         qty_ff   <= '0;
         tref_ff  <= '0;
      end else begin
         field_ff <= field_in;
         acc_ff   <= acc_in;
         dc_ff    <= dc_in;
         neg_ff   <= neg_in;
         fs_ff    <= fs_in;
         bcd_ff   <= bcd_in;
         err_ff   <= err_in;
         id_ff    <= id_in;
         code_ff  <= code_in;
         sell_ff  <= sell_in;
         tbcd_ff  <= tbcd_in;
         oref_ff  <= oref_in;
         act_ff   <= act_in;
         price_ff <= price_in;
         qty_ff   <= qty_in;
         tref_ff  <= tref_in;
      end
   end

endmodule

// ----- hdl/ocsv_rsp_fifo.sv -----
module ocsv_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  ocsv_pkg::rsp_word_type wr_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ocsv_pkg::rsp_word_type rsp_word
);
   import ocsv_pkg::*;

   rsp_word_type mem [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         rd_en;

   always_comb begin
      rd_en     = rsp_valid && rsp_ready;
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_word  = mem[rd_ptr_ff];

endmodule

// ----- hdl/order_event_csv_line_parser_core.sv -----
// Parses one comma-separated order-event line, one byte per word on the req_ channel, and
// returns one decoded event on the rsp_ channel for the word flagged line_end. A byte is
// taken every cycle: each byte passes through the digit and field logic as it is accepted, and
// the event leaves through a two-word output buffer, so req_ready drops only while two events
// wait unread. The event is registered in that buffer and shows on rsp_ behind any unread ones.
module order_event_csv_line_parser_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ocsv_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ocsv_pkg::rsp_word_type rsp_word
);
   import ocsv_pkg::*;

   logic         accept;
   logic         full;
   logic         rsp_write;
   logic [47:0]  time_bcd;
   logic [38:0]  time_us;
   rsp_word_type rsp_data;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   ocsv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .time_us   (time_us),
      .time_bcd  (time_bcd),
      .rsp_write (rsp_write),
      .rsp_data  (rsp_data)
   );

   ocsv_time_conv u_time_conv (
      .clock    (clock),
      .time_bcd (time_bcd),
      .time_us  (time_us)
   );

   ocsv_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (rsp_write),
      .wr_data   (rsp_data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTH
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != STATUS_OK) |->
         (rsp_word.event_id == 0) && (rsp_word.order_ref == 0) && (rsp_word.time_us == 0))
      else $error("error event carries field data");
   a_full_valid: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no event pending");
   a_trade_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.action_code != ACTION_TRADE) |->
         (rsp_word.trade_ref == 0) && (rsp_word.trade_price == 0))
      else $error("trade fields set on non-trade event");
   a_action_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == STATUS_OK) |-> (rsp_word.action_code != 2'd3))
      else $error("undefined action code");
`endif

endmodule

// ----- tb/tb_order_event_csv_line_parser_core.sv -----
module tb_order_event_csv_line_parser_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ocsv_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   order_event_csv_line_parser_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   localparam logic [63:0] PRICE_LIMIT = 64'hFFFF_FFFF_FFFF;

   rsp_word_type event_queue[$];
   int           mismatches = 0;
   int           idle_mode = 1;

   logic [3:0]  fld;
   logic [63:0] acc;
   int          ndig;
   logic        neg;
   int          frac;
   logic [63:0] tdig;
   logic [1:0]  err;
   logic [63:0] vals[10];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("order_event_csv_line_parser_core verification failed");
      $finish;
   end

   function automatic logic [63:0] p10(input int n);
      logic [63:0] v;
      v = 1;
      for (int i = 0; i < n; i++) v = v * 10;
      return v;
   endfunction

   task automatic clear_parse();
      fld = FLD_ID;
      acc = 0; ndig = 0; neg = 0; frac = 0; tdig = 0;
      err = STATUS_OK;
      for (int i = 0; i < 10; i++) vals[i] = 0;
   endtask

   task automatic raise(input logic [1:0] code);
      if (err == STATUS_OK) err = code;
   endtask

   task automatic open_field();
      acc = 0; tdig = 0; ndig = 0; neg = 0; frac = 0;
   endtask

   function automatic logic trade_line();
      return vals[FLD_ACTION] == 64'(ACTION_TRADE);
   endfunction

   task automatic close_field(input logic [3:0] f, output logic ok);
      logic [63:0] t;
      ok = 1'b0;
      case (f)
         FLD_CODE: begin
            vals[f] = acc; ok = 1'b1;
         end
         FLD_SIDE, FLD_ACTION: begin
            if (ndig != 1) raise(STATUS_BAD);
            else begin vals[f] = acc; ok = 1'b1; end
         end
         FLD_TIME: begin
            if (ndig == 0) raise(STATUS_BAD);
            else begin
               t = tdig;
               vals[f] = (t / 64'd10000000000) * 64'd3600000000
                       + ((t / 64'd100000000) % 100) * 64'd60000000
                       + ((t / 64'd1000000) % 100) * 64'd1000000
                       + ((t / 64'd1000) % 1000) * 64'd1000 + t % 1000;
               ok = 1'b1;
            end
         end
         FLD_ID, FLD_QTY: begin
            if (ndig == 0) raise(STATUS_BAD);
            else begin
               t = neg ? (64'd0 - acc) : acc;
               vals[f] = t & 64'hFFFF_FFFF;
               ok = 1'b1;
            end
         end
         default: begin
            if (ndig == 0) raise(STATUS_BAD);
            else begin vals[f] = acc; ok = 1'b1; end
         end
      endcase
   endtask

   task automatic parse_byte(input logic [7:0] c);
      logic        dg;
      logic [63:0] d, nv, lim;
      logic        ok;
      dg = c >= CHAR_ZERO && c <= CHAR_NINE;
      d = dg ? 64'(c - CHAR_ZERO) : 64'd0;
      if (fld >= FLD_TREF && !trade_line()) begin
         if (fld == FLD_TREF && c == CHAR_COMMA) begin
            fld = FLD_TPRICE; open_field();
         end else raise(STATUS_BAD);
         return;
      end
      if (c == CHAR_COMMA) begin
         if (fld >= FLD_TPRICE) begin raise(STATUS_BAD); return; end
         close_field(fld, ok);
         if (!ok) return;
         fld = fld + 4'd1;
         open_field();
         return;
      end
      case (fld)
         FLD_ID, FLD_QTY: begin
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               if (ndig == 0 && frac == 0) begin
                  frac = 1; neg = (c == CHAR_MINUS);
               end else raise(STATUS_BAD);
            end else if (dg) begin
               lim = neg ? 64'd2147483648 : 64'd2147483647;
               nv = acc * 10 + d;
               if (nv > lim) raise(STATUS_OVF);
               else begin acc = nv; if (ndig < 31) ndig++; end
            end else raise(STATUS_BAD);
         end
         FLD_CODE: begin
            if ((c >= CHAR_A && c <= CHAR_Z) || dg) begin
               if (ndig >= CODE_CHARS) raise(STATUS_OVF);
               else begin
                  acc = acc | (64'(c) << (56 - 8 * ndig));
                  ndig++;
               end
            end else raise(STATUS_BAD);
         end
         FLD_SIDE: begin
            if (ndig == 0 && (c == CHAR_B || c == CHAR_S)) begin
               acc = 64'(c == CHAR_S); ndig = 1;
            end else raise(STATUS_BAD);
         end
         FLD_ACTION: begin
            if (ndig == 0 && c >= CHAR_ZERO && c <= CHAR_TWO) begin
               acc = d; ndig = 1;
            end else raise(STATUS_BAD);
         end
         FLD_TIME: begin
            if (dg) begin
               nv = tdig * 10 + d;
               if (nv > p10(TIME_DIGITS) - 1) raise(STATUS_OVF);
               else begin tdig = nv; if (ndig < 31) ndig++; end
            end else raise(STATUS_BAD);
         end
         FLD_ORDER, FLD_TREF: begin
            if (dg) begin
               if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) raise(STATUS_OVF);
               else begin acc = acc * 10 + d; if (ndig < 31) ndig++; end
            end else raise(STATUS_BAD);
         end
         default: begin
            if (c == CHAR_POINT) begin
               if (frac == 0) frac = 1;
               else raise(STATUS_BAD);
            end else if (dg) begin
               if (frac == 0) nv = acc * 10 + d * p10(PRICE_FRAC_DIGITS);
               else if (frac - 1 < PRICE_FRAC_DIGITS) begin
                  nv = acc + d * p10(PRICE_FRAC_DIGITS - frac);
                  frac++;
               end else nv = acc;
               if (nv > PRICE_LIMIT) raise(STATUS_OVF);
               else begin acc = nv; if (ndig < 31) ndig++; end
            end else raise(STATUS_BAD);
         end
      endcase
   endtask

   task automatic predict_word(input req_word_type w);
      rsp_word_type r;
      logic         ok;
      if (err == STATUS_OK) parse_byte(w.char_byte);
      if (!w.line_end) return;
      if (err == STATUS_OK) begin
         if (fld == FLD_TPRICE) begin
            if (trade_line()) close_field(FLD_TPRICE, ok);
         end else raise(STATUS_EARLY);
      end
      r = '0;
      r.status = err;
      if (err == STATUS_OK) begin
         r.event_id      = vals[FLD_ID][31:0];
         r.security_code = vals[FLD_CODE];
         r.is_sell       = vals[FLD_SIDE][0];
         r.time_us       = vals[FLD_TIME][38:0];
         r.order_ref     = vals[FLD_ORDER];
         r.action_code   = vals[FLD_ACTION][1:0];
         r.price         = vals[FLD_PRICE][47:0];
         r.quantity      = vals[FLD_QTY][31:0];
         r.trade_ref     = vals[FLD_TREF];
         r.trade_price   = vals[FLD_TPRICE][47:0];
      end
      event_queue.push_back(r);
      clear_parse();
   endtask

   function automatic int draw_gap();
      if (idle_mode == 0) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
      return 0;
   endfunction

   task automatic send_word(input logic [7:0] c, input logic e);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= '{char_byte: c, line_end: e};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word('{char_byte: c, line_end: e});
      @(negedge clock);
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
   endtask

   initial begin
      int w;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         w = draw_gap();
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset || !(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      rsp_word_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (event_queue.size() == 0) begin
            $error("event with nothing expected");
            mismatches++;
         end else begin
            x = event_queue.pop_front();
            if (rsp_word.status !== x.status) begin
               $error("status exp %0d got %0d", x.status, rsp_word.status); mismatches++;
            end
            if (rsp_word.event_id !== x.event_id) begin
               $error("event_id exp %0d got %0d", x.event_id, rsp_word.event_id); mismatches++;
            end
            if (rsp_word.security_code !== x.security_code) begin
               $error("security_code exp %h got %h", x.security_code, rsp_word.security_code);
               mismatches++;
            end
            if (rsp_word.is_sell !== x.is_sell) begin
               $error("is_sell exp %0d got %0d", x.is_sell, rsp_word.is_sell); mismatches++;
            end
            if (rsp_word.time_us !== x.time_us) begin
               $error("time_us exp %0d got %0d", x.time_us, rsp_word.time_us); mismatches++;
            end
            if (rsp_word.order_ref !== x.order_ref) begin
               $error("order_ref exp %0d got %0d", x.order_ref, rsp_word.order_ref);
               mismatches++;
            end
            if (rsp_word.action_code !== x.action_code) begin
               $error("action_code exp %0d got %0d", x.action_code, rsp_word.action_code);
               mismatches++;
            end
            if (rsp_word.price !== x.price) begin
               $error("price exp %0d got %0d", x.price, rsp_word.price); mismatches++;
            end
            if (rsp_word.quantity !== x.quantity) begin
               $error("quantity exp %0d got %0d", x.quantity, rsp_word.quantity); mismatches++;
            end
            if (rsp_word.trade_ref !== x.trade_ref) begin
               $error("trade_ref exp %0d got %0d", x.trade_ref, rsp_word.trade_ref);
               mismatches++;
            end
            if (rsp_word.trade_price !== x.trade_price) begin
               $error("trade_price exp %0d got %0d", x.trade_price, rsp_word.trade_price);
               mismatches++;
            end
         end
      end
   end

   function automatic string rand_digits(input int lo, input int hi);
      string s;
      s = "";
      repeat ($urandom_range(lo, hi)) s = {s, string'(8'($urandom_range(48, 57)))};
      return s;
   endfunction

   function automatic string rand_code();
      string s;
      int    k;
      s = "";
      k = ($urandom_range(0, 9) == 0) ? 9 : $urandom_range(0, 8);
      repeat (k) begin
         if ($urandom_range(0, 1)) s = {s, string'(8'($urandom_range(65, 90)))};
         else s = {s, string'(8'($urandom_range(48, 57)))};
      end
      return s;
   endfunction

   function automatic string rand_price();
      string s;
      s = rand_digits($urandom_range(0, 1), $urandom_range(1, 11));
      if ($urandom_range(0, 1)) s = {s, ".", rand_digits(0, 7)};
      if (s.len() == 0) s = "0";
      return s;
   endfunction

   function automatic string rand_signed();
      string s;
      case ($urandom_range(0, 2))
         0: s = "";
         1: s = "+";
         default: s = "-";
      endcase
      return {s, rand_digits(1, ($urandom_range(0, 7) == 0) ? 11 : 9)};
   endfunction

   function automatic string rand_line();
      string s, a;
      int    act;
      act = $urandom_range(0, 2);
      a.itoa(act);
      s = {rand_signed(), ",", rand_code(), ",", ($urandom_range(0, 1) ? "S" : "B"), ",",
           rand_digits(1, ($urandom_range(0, 7) == 0) ? 13 : 12), ",",
           rand_digits(1, ($urandom_range(0, 7) == 0) ? 21 : 19), ",", a, ",",
           rand_price(), ",", rand_signed(), ","};
      if (act == 2) s = {s, rand_digits(1, 20), ",", rand_price()};
      else s = {s, ","};
      return s;
   endfunction

   task automatic test_directed();
      send_line("1,AAPL,B,093000123456,42,1,101.25,100,,");
      send_line("-2147483648,ZZZZ9999,S,235959999999,18446744073709551615,2,0.0001,+2147483647,18446744073709551615,28147497671.0655");
      send_line("2147483648,A,B,1,1,0,1,1,,");
      send_line("1,,B,0,0,0,.5,-0,,");
      send_line("1,ABCDEFGHI,B,0,0,0,1,1,,");
      send_line("1,A,X,0,0,0,1,1,,");
      send_line("1,A,B,9999999999999,0,0,1,1,,");
      send_line("1,A,B,0,18446744073709551616,0,1,1,,");
      send_line("1,A,B,0,0,3,1,1,,");
      send_line("1,A,B,0,0,0,1.2.3,1,,");
      send_line("1,A,B,0,0,0,123.456789,1,,");
      send_line("1,A,B,0,0,0,28147497671.0656,1,,");
      send_line("+,A,B,0,0,0,1,1,,");
      send_line("1,A,B,0,0,0,.,1,,");
      send_line("1,A,B,0,0,0,1,1,,x");
      send_line("1,A,B,0,0,2,1,1,5,1,");
      send_line("1,A,B,0,0,2,1,1,5,");
      send_line(" 1,A,B,0,0,0,1,1,,");
      send_line("1,A,B,0");
      send_line("1,a,BB,0,0,0,1,1,,");
      send_line("1,A,B,0,0,0,-1,1,,");
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
   endtask

   task automatic test_random_lines();
      string s;
      int    p;
      for (int n = 0; n < 5; n++) begin
         s = rand_line();
         if ($urandom_range(0, 4) == 0) begin
            p = $urandom_range(0, s.len() - 1);
            s[p] = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
         send_line(s);
      end
   endtask

   task automatic test_random_bytes();
      repeat (120) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      send_word(8'h2C, 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (event_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      clear_parse();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_lines();
      idle_mode = 0;
      test_random_lines();
      idle_mode = 1;
      test_random_bytes();
      drain();
      if (mismatches == 0) $display("order_event_csv_line_parser_core verification clean");
      else $display("order_event_csv_line_parser_core verification failed");
      $finish;
   end
endmodule

// ----- files.f -----
hdl/ocsv_pkg.sv
hdl/ocsv_time_conv.sv
hdl/ocsv_parser.sv
hdl/ocsv_rsp_fifo.sv
hdl/order_event_csv_line_parser_core.sv
tb/tb_order_event_csv_line_parser_core.sv
